// ----- hw/rtl/two_state_model_hamiltonian_macros.svh -----
// assertion macros used by the top-level rtl file of the two-state model block
`ifndef TWO_STATE_MODEL_HAMILTONIAN_MACROS_SVH
`define TWO_STATE_MODEL_HAMILTONIAN_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TSMH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsmh assertion failed");

// condition holds in the cycle after the trigger
`define TSMH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsmh assertion failed");

`endif

// ----- hw/rtl/tsmh_pkg.sv -----
// types, constants and coefficients of the two-state model block
package tsmh_pkg;

  // field widths
  localparam int unsigned XW  = 24;  // position, Q8.16
  localparam int unsigned HW  = 32;  // matrix element, Q1.30
  localparam int unsigned TW  = 42;  // exponent argument, Q.32
  localparam int unsigned EW  = 33;  // exponential value, Q.32 up to one
  localparam int unsigned CW  = 28;  // coefficient width
  localparam int unsigned RTW = 31;  // rate constant width
  localparam int unsigned SQW = 30;  // squared position, Q.20
  localparam int unsigned NW  = 6;   // range reduction shift

  // exponential unit
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam int unsigned EXP_NMAX = 40;
  localparam int unsigned TERMS    = 14;
  localparam int unsigned EXP_LAT  = 2 + 3 * (TERMS - 1) + 1;
  localparam int unsigned TOTAL_LAT = 3 + EXP_LAT + 3;

  // gaussian cutoff at |x| = 32.0
  localparam logic [XW-1:0] QUAD_LIMIT = XW'(32 << 16);

  // model selector codes
  typedef enum logic [1:0] {
    MODEL_ECR  = 2'd0,
    MODEL_SAC  = 2'd1,
    MODEL_DAC  = 2'd2,
    MODEL_NONE = 2'd3
  } model_e;

  // func codes
  localparam logic FUNC_H = 1'b0;
  localparam logic FUNC_D = 1'b1;

  // rate constants, Q30
  localparam logic [RTW-1:0] R_ECR   = 31'd966367642;
  localparam logic [RTW-1:0] R_B_SAC = 31'd1717986918;
  localparam logic [RTW-1:0] R_D_SAC = 31'd1073741824;
  localparam logic [RTW-1:0] R_B_DAC = 31'd300647711;
  localparam logic [RTW-1:0] R_D_DAC = 31'd64424509;

  // coefficients, Q30
  localparam logic [CW-1:0] C_A_ECR   = 28'd644245;
  localparam logic [CW-1:0] C_B_ECR   = 28'd107374182;
  localparam logic [CW-1:0] C_BC_ECR  = 28'd96636764;
  localparam logic [CW-1:0] C_A_SAC   = 28'd10737418;
  localparam logic [CW-1:0] C_AB_SAC  = 28'd17179869;
  localparam logic [CW-1:0] C_C_SAC   = 28'd5368709;
  localparam logic [CW-1:0] C_2CD_SAC = 28'd10737418;
  localparam logic [CW-1:0] C_A_DAC   = 28'd107374182;
  localparam logic [CW-1:0] C_2AB_DAC = 28'd60129542;
  localparam logic [CW-1:0] C_C_DAC   = 28'd16106127;
  localparam logic [CW-1:0] C_2CD_DAC = 28'd1932735;
  localparam logic [CW-1:0] C_E0_DAC  = 28'd53687091;

  // transaction payloads
  typedef struct packed {
    logic                 func;
    logic signed [XW-1:0] x;
  } in_t;

  typedef struct packed {
    logic signed [HW-1:0] h11;
    logic signed [HW-1:0] h22;
    logic signed [HW-1:0] h12;
  } out_t;

endpackage

// ----- hw/rtl/tsmh_exp.sv -----
// pipelined fixed-point exp(-t): range reduction by ln 2 and a taylor series
module tsmh_exp import tsmh_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [TW-1:0] t_i,
  input  logic          zero_i,
  output logic          valid_o,
  output logic [EW-1:0] e_o
);

  typedef struct packed {
    logic [31:0]   r;
    logic [31:0]   term;
    logic [33:0]   sum;
    logic [NW-1:0] n;
    logic          zero;
  } exp_st_t;

  // range reduction: n = floor(t / ln2) by parallel compares
  logic          va_q;
  logic [NW-1:0] n_d, n_q;
  logic [31:0]   tl_q;
  logic          za_d, za_q;

  always_comb begin
    n_d = '0;
    for (int k = 1; k < EXP_NMAX; k++) begin
      if (t_i >= TW'(64'(k) * 64'(LN2_Q32))) n_d = NW'(k);
    end
    za_d = zero_i | (t_i >= TW'(64'(EXP_NMAX) * 64'(LN2_Q32)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      n_q  <= n_d;
      tl_q <= t_i[31:0];
      za_q <= za_d;
    end
  end

  // remainder and first series term
  logic    vs_q [TERMS];
  exp_st_t st_q [TERMS];
  logic [31:0] r0;

  assign r0 = tl_q - 32'(38'(n_q) * 38'(LN2_Q32));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else begin
      vs_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      st_q[0].r    <= r0;
      st_q[0].term <= r0;
      st_q[0].sum  <= 34'(ONE_Q32) - 34'(r0);
      st_q[0].n    <= n_q;
      st_q[0].zero <= za_q;
    end
  end

  // one series term per three stages: multiply, divide by k, correct and sum
  for (genvar gi = 0; gi < TERMS - 1; gi++) begin : g_term
    localparam int unsigned K = gi + 2;
    localparam logic [31:0] RK = 32'((64'd1 << 32) / K);

    logic        vm_q, vq_q;
    exp_st_t     sm_q, sq_q;
    logic [31:0] p_d, pm_q, pq_q, q0_d, q0_q, rem, q;
    logic [63:0] prod_p, prod_q;

    assign prod_p = 64'(st_q[gi].term) * 64'(st_q[gi].r);
    assign p_d    = prod_p[63:32];
    assign prod_q = 64'(pm_q) * 64'(RK);
    assign q0_d   = prod_q[63:32];
    assign rem    = pq_q - 32'(q0_q * 32'(K));
    assign q      = q0_q + 32'(rem >= 32'(K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q        <= 1'b0;
        vq_q        <= 1'b0;
        vs_q[gi+1]  <= 1'b0;
      end else begin
        vm_q        <= vs_q[gi];
        vq_q        <= vm_q;
        vs_q[gi+1]  <= vq_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vs_q[gi]) begin
        sm_q <= st_q[gi];
        pm_q <= p_d;
      end
      if (vm_q) begin
        sq_q <= sm_q;
        pq_q <= pm_q;
        q0_q <= q0_d;
      end
      if (vq_q) begin
        st_q[gi+1].r    <= sq_q.r;
        st_q[gi+1].term <= q;
        st_q[gi+1].sum  <= (K % 2 == 1) ? (sq_q.sum - 34'(q)) : (sq_q.sum + 34'(q));
        st_q[gi+1].n    <= sq_q.n;
        st_q[gi+1].zero <= sq_q.zero;
      end
    end
  end

  // final scale by 2^-n
  logic [EW-1:0] e_q;
  logic          vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vs_q[TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vs_q[TERMS-1]) begin
      e_q <= st_q[TERMS-1].zero ? '0 : EW'(st_q[TERMS-1].sum >> st_q[TERMS-1].n);
    end
  end

  assign valid_o = vo_q;
  assign e_o     = e_q;

endmodule

// ----- hw/rtl/two_state_model_hamiltonian.sv -----
// top level: two-state model potentials and their derivatives, fully pipelined
//
//  channel   direction  handshake               payload
//  item      in         start, busy             in_t (func, x)
//  result    out        done_o strobe           out_t (h11, h22, h12)
//  config    in         cfg_valid_i/cfg_ready_o cfg_data_i (model select)
//
// one item enters every cycle; busy stays low and config is always ready
// the pipeline depth is set mainly by the exp units: range reduction plus
// thirteen three-stage series terms (multiply, reciprocal divide, correct)
// results appear for one cycle on done_o; there is no back-pressure
// reset clears valid bits and sets model select to the extended coupling model
`include "two_state_model_hamiltonian_macros.svh"

module two_state_model_hamiltonian import tsmh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        item_i,
  output logic       done_o,
  output out_t       result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int unsigned SW = 42;

  typedef struct packed {
    logic          func;
    logic          neg;
    logic [XW-1:0] ax;
    model_e        model;
  } side_t;

  function automatic logic signed [HW-1:0] sat32(logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'(32'sh7fff_ffff);
    lo = -SW'(33'sh0_8000_0000);
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return HW'(v);
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // model select register
  model_e model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_ECR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      model_q <= model_e'(cfg_data_i);
    end
  end

  logic in_acc;
  assign in_acc = start && !busy;

  // stage 1: magnitude and sign of x
  logic  v1_q, v2_q, v3_q;
  side_t s1_d, s1_q, s2_q, s3_q;

  always_comb begin
    s1_d.func  = item_i.func;
    s1_d.neg   = item_i.x[XW-1];
    s1_d.ax    = s1_d.neg ? XW'($unsigned(-item_i.x)) : XW'($unsigned(item_i.x));
    s1_d.model = model_q;
  end

  // stage 2: linear argument and squared position
  logic [RTW-1:0] lin_rate;
  logic [54:0]    lin_prod;
  logic [47:0]    sq_prod;
  logic [40:0]    lt_q;
  logic [SQW-1:0] sq_q;
  logic           big_q;

  always_comb begin
    case (s1_q.model)
      MODEL_ECR: lin_rate = R_ECR;
      MODEL_SAC: lin_rate = R_B_SAC;
      default:   lin_rate = '0;
    endcase
  end

  assign lin_prod = 55'(lin_rate) * 55'(s1_q.ax);
  assign sq_prod  = 48'(s1_q.ax) * 48'(s1_q.ax);

  // stage 3: exponent arguments of both units
  logic [RTW-1:0] rate_e, rate_g;
  logic [60:0]    qe_prod, qg_prod;
  logic [TW-1:0]  te_q, tg_q;
  logic           ze_q, zg_q;

  always_comb begin
    case (s2_q.model)
      MODEL_SAC: begin
        rate_e = '0;
        rate_g = R_D_SAC;
      end
      MODEL_DAC: begin
        rate_e = R_B_DAC;
        rate_g = R_D_DAC;
      end
      default: begin
        rate_e = '0;
        rate_g = '0;
      end
    endcase
  end

  assign qe_prod = 61'(rate_e) * 61'(sq_q);
  assign qg_prod = 61'(rate_g) * 61'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (v1_q) begin
      s2_q  <= s1_q;
      lt_q  <= lin_prod[54:14];
      sq_q  <= sq_prod[41:12];
      big_q <= (s1_q.ax >= QUAD_LIMIT);
    end
    if (v2_q) begin
      s3_q <= s2_q;
      te_q <= (s2_q.model == MODEL_DAC) ? qe_prod[59:18] : TW'(lt_q);
      tg_q <= qg_prod[59:18];
      ze_q <= (s2_q.model == MODEL_DAC) && big_q;
      zg_q <= big_q;
    end
  end

  // exponential units
  logic          ve, vg_unused;
  logic [EW-1:0] e_val, g_val;

  tsmh_exp u_exp_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .t_i     (te_q),
    .zero_i  (ze_q),
    .valid_o (ve),
    .e_o     (e_val)
  );

  tsmh_exp u_exp_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .t_i     (tg_q),
    .zero_i  (zg_q),
    .valid_o (vg_unused),
    .e_o     (g_val)
  );

  // side information delayed alongside the exp units
  side_t sd_q [EXP_LAT];

  always_ff @(posedge clk_i) begin
    sd_q[0] <= s3_q;
    for (int i = 1; i < EXP_LAT; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  // p1: coefficient products rounded to Q30
  side_t          se;
  logic [CW-1:0]  coef_a, coef_g;
  logic [33:0]    op_a;
  logic [61:0]    prod_a, prod_g;
  logic           vp1_q, vp2_q, vp3_q;
  side_t          sp1_q, sp2_q;
  logic [31:0]    pa_q, pg_q, pa2_q, pg2_q;

  assign se = sd_q[EXP_LAT-1];

  always_comb begin
    case (se.model)
      MODEL_ECR: begin
        coef_a = (se.func == FUNC_H) ? C_B_ECR : C_BC_ECR;
        op_a   = (se.func == FUNC_H && !se.neg) ? (34'(ONE_Q32) * 34'd2 - 34'(e_val))
                                                : 34'(e_val);
        coef_g = '0;
      end
      MODEL_SAC: begin
        coef_a = (se.func == FUNC_H) ? C_A_SAC : C_AB_SAC;
        op_a   = (se.func == FUNC_H) ? (34'(ONE_Q32) - 34'(e_val)) : 34'(e_val);
        coef_g = (se.func == FUNC_H) ? C_C_SAC : C_2CD_SAC;
      end
      MODEL_DAC: begin
        coef_a = (se.func == FUNC_H) ? C_A_DAC : C_2AB_DAC;
        op_a   = 34'(e_val);
        coef_g = (se.func == FUNC_H) ? C_C_DAC : C_2CD_DAC;
      end
      default: begin
        coef_a = '0;
        op_a   = '0;
        coef_g = '0;
      end
    endcase
  end

  assign prod_a = 62'(coef_a) * 62'(op_a) + (62'd1 << 31);
  assign prod_g = 62'(coef_g) * 62'(g_val) + (62'd1 << 31);

  // p2: products with the position magnitude
  logic [55:0] prod_xa, prod_xg;
  logic [39:0] mxa_q, mxg_q;

  assign prod_xa = 56'(pa_q) * 56'(sp1_q.ax) + 56'd32768;
  assign prod_xg = 56'(pg_q) * 56'(sp1_q.ax) + 56'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
    end else begin
      vp1_q <= ve;
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ve) begin
      sp1_q <= se;
      pa_q  <= 32'(prod_a[61:32]);
      pg_q  <= 32'(prod_g[61:32]);
    end
    if (vp1_q) begin
      sp2_q <= sp1_q;
      pa2_q <= pa_q;
      pg2_q <= pg_q;
      mxa_q <= prod_xa[55:16];
      mxg_q <= prod_xg[55:16];
    end
  end

  // p3: signs, model assembly and saturation
  logic signed [SW-1:0] pa_s, pg_s, mxa_s, mxg_s, h11_s, h22_s, h12_s;
  out_t res_d, res_q;

  always_comb begin
    pa_s  = $signed(SW'(pa2_q));
    pg_s  = $signed(SW'(pg2_q));
    mxa_s = sp2_q.neg ? -$signed(SW'(mxa_q)) : $signed(SW'(mxa_q));
    mxg_s = sp2_q.neg ? -$signed(SW'(mxg_q)) : $signed(SW'(mxg_q));
    h11_s = '0;
    h22_s = '0;
    h12_s = '0;
    case (sp2_q.model)
      MODEL_ECR: begin
        if (sp2_q.func == FUNC_H) begin
          h11_s = $signed(SW'(C_A_ECR));
          h22_s = -$signed(SW'(C_A_ECR));
        end
        h12_s = pa_s;
      end
      MODEL_SAC: begin
        h11_s = (sp2_q.func == FUNC_H && sp2_q.neg) ? -pa_s : pa_s;
        h22_s = -h11_s;
        h12_s = (sp2_q.func == FUNC_H) ? pg_s : -mxg_s;
      end
      MODEL_DAC: begin
        h22_s = (sp2_q.func == FUNC_H) ? ($signed(SW'(C_E0_DAC)) - pa_s) : mxa_s;
        h12_s = (sp2_q.func == FUNC_H) ? pg_s : -mxg_s;
      end
      default: begin
        h11_s = '0;
      end
    endcase
    res_d.h11 = sat32(h11_s);
    res_d.h22 = sat32(h22_s);
    res_d.h12 = sat32(h12_s);
  end

  always_ff @(posedge clk_i) begin
    if (vp2_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = vp3_q;
  assign result_o = res_q;

  // checks on pipeline timing and model structure
  `TSMH_ASSERT_IMP(a_latency, in_acc, ##TOTAL_LAT done_o)
  `TSMH_ASSERT_IMP(a_exp_units_aligned, ve, vg_unused)
  `TSMH_ASSERT_NXT(a_unused_model_zero, vp2_q && sp2_q.model == MODEL_NONE,
                   result_o.h11 == 0 && result_o.h22 == 0 && result_o.h12 == 0)
  `TSMH_ASSERT_NXT(a_sac_antisym, vp2_q && sp2_q.model == MODEL_SAC,
                   result_o.h22 == -result_o.h11)

endmodule
